/* sv/sacl_pkg.sv */
// Shared types and constants for the LFU cache tag directory.
// Used by the front end, the item queue, the back end and the top level.
`default_nettype none
package sacl_pkg;
	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 8;
	localparam int ADDR_WIDTH   = 32;
	localparam int COUNT_WIDTH  = 16;
	localparam int TAG_WIDTH    = 32;
	localparam int WAY_BITS     = $clog2(MAX_WAYS);
	localparam int NUM_SETS     = 1 << MAX_SET_BITS;
	localparam int QDEPTH       = 2;
	localparam int QPTR_BITS    = 1;

	localparam logic [2:0] REG_OFFSET_BITS = 3'd0;
	localparam logic [2:0] REG_INDEX_BITS  = 3'd1;
	localparam logic [2:0] REG_TAG_BITS    = 3'd2;
	localparam logic [2:0] REG_WAYS_USED   = 3'd3;
	localparam logic [2:0] REG_WRITE_ALLOC = 3'd4;

	// One classified item: split address plus what the back end needs.
	typedef struct packed {
		logic                    do_fill;
		logic [MAX_SET_BITS-1:0] set_idx;
		logic [TAG_WIDTH-1:0]    tag;
		logic [15:0]             offset;
		logic [WAY_BITS:0]       ways;
	} item_t;

	typedef struct packed {
		logic                    hit;
		logic [MAX_SET_BITS-1:0] set_idx;
		logic [WAY_BITS-1:0]     way;
		logic                    filled;
		logic                    ev_valid;
		logic [TAG_WIDTH-1:0]    ev_tag;
		logic [15:0]             offset;
	} result_t;
endpackage
`default_nettype wire

/* sv/sacl_front.sv */
// Front end: splits the address under the current geometry and classifies the item.
// Depends on sacl_pkg.
`default_nettype none
module sacl_front import sacl_pkg::*; (
	input  wire logic                  kind,
	input  wire logic [ADDR_WIDTH-1:0] address,
	input  wire logic [4:0]            offset_bits,
	input  wire logic [2:0]            index_bits,
	input  wire logic [5:0]            tag_bits,
	input  wire logic [3:0]            ways_used,
	input  wire logic                  write_allocate,
	output item_t                      item
);
	logic [2:0]  s_eff;
	logic [5:0]  t_eff;
	logic [63:0] addr_w;
	logic [63:0] sh_set;
	logic [63:0] sh_tag;
	logic [6:0]  tag_pos;
	logic [TAG_WIDTH-1:0] tmask;

	// Clamp geometry and extract fields.
	always_comb begin
		s_eff   = (index_bits > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : index_bits;
		t_eff   = (tag_bits > 6'(TAG_WIDTH)) ? 6'(TAG_WIDTH) : tag_bits;
		addr_w  = 64'(address);
		sh_set  = addr_w >> offset_bits;
		tag_pos = 7'(offset_bits) + 7'(s_eff);
		sh_tag  = addr_w >> tag_pos;
		tmask   = (t_eff == 6'(TAG_WIDTH)) ? '1 : ((TAG_WIDTH'(1) << t_eff) - TAG_WIDTH'(1));
		item.set_idx = sh_set[MAX_SET_BITS-1:0] & ((MAX_SET_BITS'(1) << s_eff) - MAX_SET_BITS'(1));
		item.tag     = sh_tag[TAG_WIDTH-1:0] & tmask;
		item.offset  = addr_w[15:0] & ((offset_bits >= 5'd16) ? 16'hFFFF
			: ((16'd1 << offset_bits) - 16'd1));
		if (ways_used == 4'd0)
			item.ways = (WAY_BITS+1)'(1);
		else if (ways_used > 4'(MAX_WAYS))
			item.ways = (WAY_BITS+1)'(MAX_WAYS);
		else
			item.ways = (WAY_BITS+1)'(ways_used);
		item.do_fill = !kind || write_allocate;
	end
endmodule
`default_nettype wire

/* sv/sacl_queue.sv */
// Two-entry queue carrying classified items from front end to back end.
// Depends on sacl_pkg.
`default_nettype none
module sacl_queue import sacl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  item_t     push_item,
	input  wire logic pop,
	output item_t     head,
	output logic      not_empty,
	output logic      full
);
	item_t                mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QPTR_BITS:0]   cnt_q;

	assign not_empty = cnt_q != '0;
	assign full      = cnt_q == (QPTR_BITS+1)'(QDEPTH);
	assign head      = mem_q[rd_q];

	// Storage writes.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
		end
	end
endmodule
`default_nettype wire

/* sv/sacl_back.sv */
// Back end: set read, way search, LFU victim choice and directory update.
// Depends on sacl_pkg. Holds the directory memory and the per-set valid flag memory.
`default_nettype none
module sacl_back import sacl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  item_t     in_item,
	output logic      in_pop,
	output logic      res_valid,
	output result_t   res
);
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_READ  = 4'b0010,
		ST_EVAL  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	localparam int ROW_W = MAX_WAYS * (TAG_WIDTH + COUNT_WIDTH);

	state_t state_q;
	logic [MAX_SET_BITS-1:0] clr_q;
	logic [ROW_W-1:0]    row_mem [NUM_SETS];
	logic [ROW_W-1:0]    row_q;
	logic [MAX_WAYS-1:0] vld_mem [NUM_SETS];
	logic [MAX_WAYS-1:0] vrow_q;
	item_t               it_q;
	logic [ROW_W-1:0]    new_row;
	logic [MAX_WAYS-1:0] new_vrow;
	logic                wr_en;
	result_t             r_c;
	logic [TAG_WIDTH-1:0]   tg [MAX_WAYS];
	logic [COUNT_WIDTH-1:0] ct [MAX_WAYS];
	logic                   hit_c, empty_c;
	logic [WAY_BITS-1:0]    hway, eway, lway, vway;
	logic [COUNT_WIDTH-1:0] best;

	assign in_pop = (state_q == ST_READ) && in_valid;

	// Way compare and victim search over one registered set row.
	always_comb begin
		hit_c = 1'b0; empty_c = 1'b0;
		hway = '0; eway = '0; lway = '0; best = '1;
		for (int i = MAX_WAYS-1; i >= 0; i--) begin
			tg[i] = row_q[i*(TAG_WIDTH+COUNT_WIDTH) +: TAG_WIDTH];
			ct[i] = row_q[i*(TAG_WIDTH+COUNT_WIDTH)+TAG_WIDTH +: COUNT_WIDTH];
			if ((WAY_BITS+1)'(i) < it_q.ways) begin
				if (vrow_q[i] && tg[i] == it_q.tag) begin hit_c = 1'b1; hway = WAY_BITS'(i); end
				if (!vrow_q[i]) begin empty_c = 1'b1; eway = WAY_BITS'(i); end
			end
		end
		for (int i = 0; i < MAX_WAYS; i++)
			if ((WAY_BITS+1)'(i) < it_q.ways && vrow_q[i] && (i == 0 || ct[i] < best)) begin
				if (ct[i] < best || i == 0) begin best = ct[i]; lway = WAY_BITS'(i); end
			end
		vway = empty_c ? eway : lway;
		new_row  = row_q;
		new_vrow = vrow_q;
		wr_en    = 1'b0;
		r_c.set_idx = it_q.set_idx;
		r_c.offset  = it_q.offset;
		r_c.hit = hit_c; r_c.way = '0; r_c.filled = 1'b0;
		r_c.ev_valid = 1'b0; r_c.ev_tag = '0;
		if (hit_c) begin
			r_c.way = hway;
			wr_en = 1'b1;
			if (ct[hway] != '1)
				new_row[32'(hway)*(TAG_WIDTH+COUNT_WIDTH)+TAG_WIDTH +: COUNT_WIDTH] =
					ct[hway] + COUNT_WIDTH'(1);
		end else if (it_q.do_fill) begin
			wr_en = 1'b1;
			r_c.way = vway; r_c.filled = 1'b1;
			r_c.ev_valid = !empty_c;
			r_c.ev_tag = empty_c ? '0 : tg[vway];
			new_row[32'(vway)*(TAG_WIDTH+COUNT_WIDTH) +: TAG_WIDTH] = it_q.tag;
			new_row[32'(vway)*(TAG_WIDTH+COUNT_WIDTH)+TAG_WIDTH +: COUNT_WIDTH] = COUNT_WIDTH'(1);
			new_vrow[vway] = 1'b1;
		end
	end

	// Directory and valid flag memories: one row read, one row written back.
	// After reset the valid flags are cleared one set per cycle.
	always_ff @(posedge clk) begin
		if (in_pop) begin
			row_q  <= row_mem[in_item.set_idx];
			vrow_q <= vld_mem[in_item.set_idx];
			it_q   <= in_item;
		end
		if (state_q == ST_CLEAR) begin
			vld_mem[clr_q] <= '0;
		end else if (state_q == ST_EVAL && wr_en) begin
			row_mem[it_q.set_idx] <= new_row;
			vld_mem[it_q.set_idx] <= new_vrow;
		end
		if (state_q == ST_EVAL) res <= r_c;
	end

	// Sequencer: clear after reset, then read, evaluate and write, present.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; res_valid <= 1'b0; clr_q <= '0;
		end else begin
			res_valid <= state_q == ST_EVAL;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			unique case (state_q)
				ST_CLEAR: if (clr_q == '1) state_q <= ST_READ;
				ST_READ: if (in_valid) state_q <= ST_EVAL;
				ST_EVAL: state_q <= ST_DONE;
				ST_DONE: state_q <= ST_READ;
				default: state_q <= ST_READ;
			endcase
		end
	end
endmodule
`default_nettype wire

/* sv/set_assoc_cache_lfu_directory.sv */
// Top level of the LFU cache tag directory: configuration registers and wiring.
// Depends on sacl_pkg, sacl_front, sacl_queue and sacl_back.
// Usage:
//   Raise start with kind and address; the item is taken at a rising edge
//   where start is high and busy is low. Busy is high while the queue is full.
//   Each item yields one result on hit, set_index, way, filled, evicted_valid,
//   evicted_tag and block_offset, marked by done for exactly one cycle.
//   The receiver cannot stall; results leave in item order.
//   An accepted item waits in the queue until the back end reads its set row;
//   the back end takes no new item until it has run its read, update and
//   present sequence on the single-port set row memory for the last one.
//   Configuration: cfg_we, cfg_index, cfg_data write register cfg_index at once.
//   Reset clears the queue and the sequencer and restores register defaults
//   (offset 4, index 2, tag 26, ways 2, allocate 1). The back end then clears
//   the valid flags of all 64 sets, one set per cycle; items taken during
//   that pass wait in the queue, and busy rises once the queue is full.
`default_nettype none
module set_assoc_cache_lfu_directory import sacl_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    kind,
	input  wire logic [ADDR_WIDTH-1:0]   address,
	input  wire logic                    cfg_we,
	input  wire logic [2:0]              cfg_index,
	input  wire logic [5:0]              cfg_data,
	output logic                         done,
	output logic                         hit,
	output logic [MAX_SET_BITS-1:0]      set_index,
	output logic [WAY_BITS-1:0]          way,
	output logic                         filled,
	output logic                         evicted_valid,
	output logic [TAG_WIDTH-1:0]         evicted_tag,
	output logic [15:0]                  block_offset
);
	logic [4:0] offset_bits_q;
	logic [2:0] index_bits_q;
	logic [5:0] tag_bits_q;
	logic [3:0] ways_used_q;
	logic       write_allocate_q;
	item_t      f_item, q_head;
	logic       q_ne, q_full, pop, accept;
	result_t    res;

	assign busy   = q_full;
	assign accept = start && !busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= 5'd4; index_bits_q <= 3'd2; tag_bits_q <= 6'd26;
			ways_used_q <= 4'd2; write_allocate_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFFSET_BITS: offset_bits_q    <= cfg_data[4:0];
				REG_INDEX_BITS:  index_bits_q     <= cfg_data[2:0];
				REG_TAG_BITS:    tag_bits_q       <= cfg_data;
				REG_WAYS_USED:   ways_used_q      <= cfg_data[3:0];
				REG_WRITE_ALLOC: write_allocate_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sacl_front u_front (
		.kind(kind), .address(address), .offset_bits(offset_bits_q),
		.index_bits(index_bits_q), .tag_bits(tag_bits_q), .ways_used(ways_used_q),
		.write_allocate(write_allocate_q), .item(f_item)
	);

	sacl_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(accept), .push_item(f_item),
		.pop(pop), .head(q_head), .not_empty(q_ne), .full(q_full)
	);

	sacl_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_ne), .in_item(q_head),
		.in_pop(pop), .res_valid(done), .res(res)
	);

	assign hit           = res.hit;
	assign set_index     = res.set_idx;
	assign way           = res.way;
	assign filled        = res.filled;
	assign evicted_valid = res.ev_valid;
	assign evicted_tag   = res.ev_tag;
	assign block_offset  = res.offset;

`ifndef SYNTHESIS
	a_hit_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && filled)) else $error("hit and fill together");
	a_evict_needs_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done && evicted_valid |-> filled) else $error("eviction without fill");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back results");
`endif
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the LFU cache tag directory (set_assoc_cache_lfu_directory).
// Depends on sacl_pkg for widths, register indexes and the result layout.
// A scoreboard class predicts each result and compares it with what the block returns.
`default_nettype none
module tb_top;
	import sacl_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS = 150;
	localparam int NUM_PHASES = 10;
	localparam int HOT_HITS = 40;

	// Directory model and expected-result store.
	class lfu_scoreboard;
		bit        line_ok  [NUM_SETS*MAX_WAYS];
		bit [31:0] line_tag [NUM_SETS*MAX_WAYS];
		int        line_uses[NUM_SETS*MAX_WAYS];
		int        off_bits, idx_bits, tag_len, ways, wr_alloc;
		result_t   expected_q[$];
		int        errors;

		function new();
			foreach (line_ok[i]) begin
				line_ok[i] = 0;
				line_tag[i] = 0;
				line_uses[i] = 0;
			end
			off_bits = 4;
			idx_bits = 2;
			tag_len = 26;
			ways = 2;
			wr_alloc = 1;
			errors = 0;
		endfunction

		function bit [63:0] ones(int n);
			if (n >= 64) return '1;
			return (64'd1 << n) - 1;
		endfunction

		function int eff_sets();
			return idx_bits > MAX_SET_BITS ? MAX_SET_BITS : idx_bits;
		endfunction

		function int eff_tag();
			return tag_len > 32 ? 32 : tag_len;
		endfunction

		function void set_reg(logic [2:0] idx, int val);
			case (idx)
				REG_OFFSET_BITS: off_bits = val & 31;
				REG_INDEX_BITS:  idx_bits = val & 7;
				REG_TAG_BITS:    tag_len = val & 63;
				REG_WAYS_USED:   ways = val & 15;
				REG_WRITE_ALLOC: wr_alloc = val & 1;
				default: ;
			endcase
		endfunction

		// Work out the directory lookup and fill for one accepted item.
		function void note(bit is_wr, logic [31:0] addr);
			bit [63:0] a64;
			bit [63:0] setv;
			bit [31:0] tagv;
			int s, t, e, base, victim, best, k;
			bit empty_found;
			result_t r;
			a64 = {32'd0, addr};
			s = eff_sets();
			t = eff_tag();
			e = ways == 0 ? 1 : (ways > MAX_WAYS ? MAX_WAYS : ways);
			setv = (a64 >> off_bits) & ones(s);
			tagv = 32'((a64 >> (off_bits + s)) & ones(t));
			base = int'(setv) * MAX_WAYS;
			r = '0;
			r.set_idx = setv[MAX_SET_BITS-1:0];
			r.offset = 16'(a64 & ones(off_bits));
			for (int i = 0; i < e; i++) begin
				k = base + i;
				if (line_ok[k] && line_tag[k] == tagv) begin
					r.hit = 1;
					r.way = WAY_BITS'(i);
					if (line_uses[k] < 65535) line_uses[k]++;
					break;
				end
			end
			// On a miss that fills (a read, or a write with allocation), pick the first empty way, else the least used one.
			if (!r.hit && (!is_wr || wr_alloc)) begin
				victim = 0;
				best = 32'h7fffffff;
				empty_found = 0;
				for (int i = 0; i < e; i++) begin
					k = base + i;
					if (!line_ok[k]) begin
						victim = i;
						empty_found = 1;
						break;
					end
					if (line_uses[k] < best) begin
						best = line_uses[k];
						victim = i;
					end
				end
				k = base + victim;
				if (!empty_found) begin
					r.ev_valid = 1;
					r.ev_tag = line_tag[k];
				end
				line_ok[k] = 1;
				line_tag[k] = tagv;
				line_uses[k] = 1;
				r.filled = 1;
				r.way = WAY_BITS'(victim);
			end
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		// Compare one returned result with the oldest prediction.
		task check(result_t got);
			result_t w;
			if (expected_q.size() == 0) begin
				report("result with no item outstanding");
				return;
			end
			w = expected_q.pop_front();
			if (got.hit !== w.hit) report($sformatf("hit %b, want %b", got.hit, w.hit));
			if (got.set_idx !== w.set_idx)
				report($sformatf("set_index %0d, want %0d", got.set_idx, w.set_idx));
			if (got.way !== w.way) report($sformatf("way %0d, want %0d", got.way, w.way));
			if (got.filled !== w.filled)
				report($sformatf("filled %b, want %b", got.filled, w.filled));
			if (got.ev_valid !== w.ev_valid)
				report($sformatf("evicted_valid %b, want %b", got.ev_valid, w.ev_valid));
			if (got.ev_tag !== w.ev_tag)
				report($sformatf("evicted_tag %h, want %h", got.ev_tag, w.ev_tag));
			if (got.offset !== w.offset)
				report($sformatf("block_offset %h, want %h", got.offset, w.offset));
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    kind;
	logic [ADDR_WIDTH-1:0]   address;
	logic                    cfg_we;
	logic [2:0]              cfg_index;
	logic [5:0]              cfg_data;
	logic                    done;
	logic                    hit;
	logic [MAX_SET_BITS-1:0] set_index;
	logic [WAY_BITS-1:0]     way;
	logic                    filled;
	logic                    evicted_valid;
	logic [TAG_WIDTH-1:0]    evicted_tag;
	logic [15:0]             block_offset;

	lfu_scoreboard sb = new();
	int cycles = 0;

	set_assoc_cache_lfu_directory i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.address(address), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .hit(hit), .set_index(set_index), .way(way), .filled(filled),
		.evicted_valid(evicted_valid), .evicted_tag(evicted_tag), .block_offset(block_offset)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[set_assoc_cache_lfu_directory] ERROR");
			$finish;
		end
	end

	// Results are stable around the falling edge.
	always @(negedge clk) begin
		result_t got;
		if (arst_n && done) begin
			got.hit = hit;
			got.set_idx = set_index;
			got.way = way;
			got.filled = filled;
			got.ev_valid = evicted_valid;
			got.ev_tag = evicted_tag;
			got.offset = block_offset;
			sb.check(got);
		end
	end

	// Present one item and hold it until the block takes it; called just after an edge.
	task send_item(bit k, logic [31:0] a);
		bit taken;
		start <= 1;
		kind <= k;
		address <= a;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		sb.note(k, a);
	endtask

	// Stop sending, let every expected result come back, then let the pipe settle.
	task drain();
		start <= 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_regs(int ob, int ib, int tb, int wu, int wa);
		logic [2:0] idx [5];
		int val [5];
		idx = '{REG_OFFSET_BITS, REG_INDEX_BITS, REG_TAG_BITS, REG_WAYS_USED, REG_WRITE_ALLOC};
		val = '{ob, ib, tb, wu, wa};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1;
			cfg_index <= idx[i];
			cfg_data <= 6'(val[i]);
			sb.set_reg(idx[i], val[i]);
			@(posedge clk);
		end
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// Random address that often reuses a few tags in a few sets, so hits and evictions occur.
	function logic [31:0] pick_address();
		bit [63:0] a64, fm;
		int s, t, lo;
		a64 = {32'd0, $urandom()};
		s = sb.eff_sets();
		t = sb.eff_tag();
		lo = sb.off_bits + s;
		if ($urandom_range(0, 3) != 0) begin
			fm = sb.ones(t) << lo;
			a64 = (a64 & ~fm) | ((64'($urandom_range(0, 4)) << lo) & fm);
		end
		if ($urandom_range(0, 2) != 0) begin
			fm = sb.ones(s) << sb.off_bits;
			a64 = (a64 & ~fm) | ((64'($urandom_range(0, 1)) << sb.off_bits) & fm);
		end
		return a64[31:0];
	endfunction

	initial begin
		int ob, ib, tb, wu, wa;
		arst_n = 0;
		start = 0;
		kind = 0;
		address = '0;
		cfg_we = 0;
		cfg_index = REG_OFFSET_BITS;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(posedge clk);

		// Directed items at the reset geometry: extremes, fills, evictions, write hits.
		send_item(0, 32'h0000_0000);
		send_item(1, 32'hFFFF_FFFF);
		send_item(0, 32'h0000_0000);
		send_item(0, 32'h0000_0100);
		send_item(0, 32'h0000_0200);
		send_item(1, 32'h0000_0200);
		send_item(0, 32'h0000_0305);
		send_item(1, 32'hFFFF_FFF0);
		send_item(0, 32'h8000_002A);
		drain();
		// Write miss without allocation.
		write_regs(4, 2, 26, 2, 0);
		send_item(1, 32'h1234_5670);
		send_item(1, 32'h0000_0200);
		send_item(0, 32'h0000_0000);
		send_item(0, 32'h1234_5670);
		drain();

		// Use counts: one line hit many times, then a new line evicts the other, less used
		// line, and the next miss must evict that newer, less used line.
		write_regs(4, 2, 26, 2, 1);
		for (int i = 0; i < HOT_HITS; i++) send_item(0, 32'h0000_4440);
		send_item(0, 32'h0000_5540);
		send_item(0, 32'h0000_6640);
		send_item(0, 32'h0000_4440);
		drain();

		// Random phases, each with a new geometry; stored lines survive the change.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin ob = 0;  ib = 0; tb = 0;  wu = 0;  wa = 0; end
				1: begin ob = 31; ib = 7; tb = 63; wu = 15; wa = 1; end
				2: begin ob = 16; ib = 6; tb = 32; wu = 8;  wa = 0; end
				3: begin ob = 2;  ib = 3; tb = 5;  wu = 1;  wa = 1; end
				default: begin
					ob = $urandom_range(0, 31);
					ib = $urandom_range(0, 7);
					tb = $urandom_range(0, 63);
					wu = $urandom_range(0, 15);
					wa = $urandom_range(0, 1);
				end
			endcase
			write_regs(ob, ib, tb, wu, wa);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p < NUM_PHASES - 1 && $urandom_range(0, 3) == 0) begin
					start <= 0;
					repeat ($urandom_range(1, 15)) @(posedge clk);
				end
				send_item($urandom_range(0, 1), pick_address());
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("[set_assoc_cache_lfu_directory] OK");
		end else begin
			$display("[set_assoc_cache_lfu_directory] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
sv/sacl_pkg.sv
sv/sacl_front.sv
sv/sacl_queue.sv
sv/sacl_back.sv
sv/set_assoc_cache_lfu_directory.sv
bench/tb_top.sv
